// ----- rtl/core/tkc_pkg.sv -----
// ----------------------------------------------------------------------------
// tkc_pkg: shared types and constants of the touch keypad calculator
// Key codes, payload structs, FSM/operation/display enums, and the touch-zone
// decoder for the fixed 4x4 button grid plus the clear zone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkc_pkg;

  // Key codes as seen on the result channel
  localparam logic [4:0] K_D9   = 5'd9;
  localparam logic [4:0] K_ADD  = 5'd10;
  localparam logic [4:0] K_SUB  = 5'd11;
  localparam logic [4:0] K_MUL  = 5'd12;
  localparam logic [4:0] K_DIV  = 5'd13;
  localparam logic [4:0] K_EQ   = 5'd14;
  localparam logic [4:0] K_CLR  = 5'd15;
  localparam logic [4:0] K_BACK = 5'd16;
  localparam logic [4:0] K_NONE = 5'd17;

  // Button grid bounds (strict on both sides)
  localparam logic [8:0] COL_LO [4] = '{9'd0,   9'd120, 9'd240, 9'd360};
  localparam logic [8:0] COL_HI [4] = '{9'd115, 9'd235, 9'd355, 9'd480};
  localparam logic [8:0] ROW_LO [4] = '{9'd88,  9'd146, 9'd204, 9'd262};
  localparam logic [8:0] ROW_HI [4] = '{9'd144, 9'd202, 9'd260, 9'd320};

  // Clear zone in the top right corner
  localparam logic [8:0] CLR_X_LO = 9'd400;
  localparam logic [8:0] CLR_X_HI = 9'd480;
  localparam logic [8:0] CLR_Y_LO = 9'd0;
  localparam logic [8:0] CLR_Y_HI = 9'd80;

  // Key per [column][row]
  localparam logic [4:0] GRID_KEYS [4][4] = '{
    '{5'd7,  5'd4,  5'd1,  5'd0},
    '{5'd8,  5'd5,  5'd2,  K_BACK},
    '{5'd9,  5'd6,  5'd3,  K_ADD},
    '{K_DIV, K_MUL, K_SUB, K_EQ}
  };

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_SHOW  = 2'd1,
    MODE_BLANK = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DIVFIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [8:0] touch_x;
    logic [8:0] touch_y;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         key_code;
    logic [1:0]         show_mode;
    logic signed [31:0] display_value;
    logic               leave_page;
    logic               div_by_zero;
  } out_item_t;

  // Touch coordinate to key code; zones never overlap
  function automatic logic [4:0] decode_key(input logic [8:0] x, input logic [8:0] y);
    logic [4:0] k;
    k = K_NONE;
    if (x > CLR_X_LO && x < CLR_X_HI && y > CLR_Y_LO && y < CLR_Y_HI) begin
      k = K_CLR;
    end else begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          if (x > COL_LO[c] && x < COL_HI[c] && y > ROW_LO[r] && y < ROW_HI[r]) begin
            k = GRID_KEYS[c][r];
          end
        end
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/touch_keypad_calculator.sv -----
// ----------------------------------------------------------------------------
// touch_keypad_calculator: four-function calculator behind a touch keypad
// Decodes touch coordinates into keys, enters decimal operands and computes
// add and subtract directly, and multiply and signed divide with a shared bit-serial engine.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_i) carries one touch
//   coordinate pair per transfer. Output channel (out_valid_o / out_stall_i /
//   out_o) carries exactly one result per input transfer, in order.
//   One item is worked on at a time; in_stall_o is low only while idle.
//   Steps from input transfer to result valid, by key:
//     operator, equals add/sub/none, divide by zero, clear, back, no key:
//       execute, then done; digit key: serial x10 over the bits of ten
//     equals multiply: one multiplier bit per cycle, ends early once the
//       remaining bits are zero
//     equals divide: restoring divider, one quotient bit per cycle, then
//       the quotient sign is applied
//   The block returns to idle before it takes the next input transfer, so
//   the shift-add/subtract engine sets the rate for multiply or divide.
//   Reset clears operands, result, operation and entry mode to zero.
//   A stalled result is held in the output register; the next input is
//   taken once the current item's result has been loaded there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module touch_keypad_calculator
  import tkc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_o
);

  localparam int W    = VALUE_WIDTH;
  localparam int CntW = $clog2(VALUE_WIDTH + 1);

  // Architectural state
  logic [W-1:0] first_q, first_d;
  logic [W-1:0] second_q, second_d;
  logic [W-1:0] result_q, result_d;
  op_e          op_q, op_d;
  logic         entering_q, entering_d;

  // Per-item control
  state_e       state_q, state_d;
  logic [4:0]   key_q, key_d;
  mode_e        mode_q, mode_d;
  logic         dz_q, dz_d;
  logic         neg_q, neg_d;
  logic [W-1:0] val_q, val_d;

  // Serial engine: accumulator/remainder, shifting operands, bit counter
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    opa_q, opa_d;
  logic [W-1:0]    opb_q, opb_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      out_load;

  // Engine arithmetic
  logic [W-1:0] add_sum;
  logic [W-1:0] sub_diff;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W-1:0] div_trial;
  logic [W:0]   div_diff;
  logic [W-1:0] quot;
  logic         key_is_digit;

  assign add_sum      = first_q + second_q;
  assign sub_diff     = first_q - second_q;
  assign mag_a        = first_q[W-1] ? (W'(0) - first_q) : first_q;
  assign mag_b        = second_q[W-1] ? (W'(0) - second_q) : second_q;
  assign div_trial    = {acc_q[W-2:0], opa_q[W-1]};
  assign div_diff     = {1'b0, div_trial} - {1'b0, opb_q};
  assign quot         = neg_q ? (W'(0) - opa_q) : opa_q;
  assign key_is_digit = (key_q <= K_D9);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        if (key_is_digit) begin
          state_d = ST_MUL;
        end else if (key_q == K_EQ && op_q == OP_MUL) begin
          state_d = ST_MUL;
        end else if (key_q == K_EQ && op_q == OP_DIV && second_q != '0) begin
          state_d = ST_DIV;
        end
      end
      ST_MUL: begin
        if (opb_q == '0) state_d = ST_DONE;
      end
      ST_DIV: begin
        if (cnt_q == CntW'(1)) state_d = ST_DIVFIX;
      end
      ST_DIVFIX: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  // Datapath
  always_comb begin
    first_d    = first_q;
    second_d   = second_q;
    result_d   = result_q;
    op_d       = op_q;
    entering_d = entering_q;
    key_d      = key_q;
    mode_d     = mode_q;
    dz_d       = dz_q;
    neg_d      = neg_q;
    val_d      = val_q;
    acc_d      = acc_q;
    opa_d      = opa_q;
    opb_d      = opb_q;
    cnt_d      = cnt_q;

    case (state_q)
      // capture the decoded key
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d  = decode_key(in_i.touch_x, in_i.touch_y);
          dz_d   = 1'b0;
          mode_d = MODE_NONE;
          val_d  = '0;
        end
      end

      // act on the key, set up the serial engine where needed
      ST_EXEC: begin
        unique case (key_q) inside
          [5'd0:K_D9]: begin
            opa_d  = entering_q ? second_q : first_q;
            opb_d  = W'(10);
            acc_d  = W'(key_q[3:0]);
            mode_d = MODE_SHOW;
          end
          K_ADD, K_SUB, K_MUL, K_DIV: begin
            op_d       = op_e'(3'(key_q - K_ADD) + 3'd1);
            entering_d = 1'b1;
            mode_d     = MODE_BLANK;
          end
          K_EQ: begin
            entering_d = 1'b0;
            mode_d     = MODE_SHOW;
            val_d      = result_q;
            case (op_q)
              OP_ADD: begin
                result_d = add_sum;
                val_d    = add_sum;
              end
              OP_SUB: begin
                result_d = sub_diff;
                val_d    = sub_diff;
              end
              OP_MUL: begin
                opa_d = first_q;
                opb_d = second_q;
                acc_d = '0;
              end
              OP_DIV: begin
                if (second_q == '0) begin
                  dz_d = 1'b1;
                end else begin
                  opa_d = mag_a;
                  opb_d = mag_b;
                  acc_d = '0;
                  neg_d = first_q[W-1] ^ second_q[W-1];
                  cnt_d = CntW'(VALUE_WIDTH);
                end
              end
              default: ;
            endcase
          end
          K_CLR: begin
            first_d    = '0;
            second_d   = '0;
            result_d   = '0;
            op_d       = OP_NONE;
            entering_d = 1'b0;
            mode_d     = MODE_SHOW;
            val_d      = '0;
          end
          default: begin
            mode_d = MODE_NONE;
          end
        endcase
      end

      // shift-add multiply, LSB of opb first
      ST_MUL: begin
        if (opb_q == '0) begin
          val_d = acc_q;
          if (key_q == K_EQ) begin
            result_d = acc_q;
          end else if (entering_q) begin
            second_d = acc_q;
          end else begin
            first_d = acc_q;
          end
        end else begin
          if (opb_q[0]) acc_d = acc_q + opa_q;
          opa_d = {opa_q[W-2:0], 1'b0};
          opb_d = {1'b0, opb_q[W-1:1]};
        end
      end

      // restoring divide of magnitudes, one quotient bit per cycle
      ST_DIV: begin
        cnt_d = cnt_q - CntW'(1);
        if (!div_diff[W]) begin
          acc_d = div_diff[W-1:0];
          opa_d = {opa_q[W-2:0], 1'b1};
        end else begin
          acc_d = div_trial;
          opa_d = {opa_q[W-2:0], 1'b0};
        end
      end

      // apply the quotient sign
      ST_DIVFIX: begin
        result_d = quot;
        val_d    = quot;
      end

      default: ;
    endcase
  end

  // Output register next value
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d           = 1'b1;
      out_d.key_code        = key_q;
      out_d.show_mode       = mode_q;
      out_d.display_value   = (mode_q == MODE_SHOW) ? 32'($signed(val_q)) : 32'sd0;
      out_d.leave_page      = (key_q == K_BACK);
      out_d.div_by_zero     = dz_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= '0;
      second_q    <= '0;
      result_q    <= '0;
      op_q        <= OP_NONE;
      entering_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      second_q    <= second_d;
      result_q    <= result_d;
      op_q        <= op_d;
      entering_q  <= entering_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and engine registers
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    mode_q <= mode_d;
    dz_q   <= dz_d;
    neg_q  <= neg_d;
    val_q  <= val_d;
    acc_q  <= acc_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside the done state");

  a_dz_only_equals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.div_by_zero || out_q.key_code == K_EQ))
    else $error("divide-by-zero flag on a key other than equals");

  a_leave_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.leave_page == (out_q.key_code == K_BACK)))
    else $error("leave flag does not match the back key");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q != '0)
    else $error("divider ran past its last bit");

  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && $past(state_q) == ST_EXEC) |-> opb_q != '0)
    else $error("divider started with a zero divisor");

endmodule

`default_nettype wire
